// ----- design/hcls_pkg.sv -----
// constants, types and per-byte line logic for the http content-length scanner
// no dependencies

package hcls_pkg;

  // width of the content_length field on the result channel
  localparam int OUT_LEN_W = 64;

  // ascii codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CASE_GAP = 8'h20;

  // length of the header name, colon included
  localparam logic [3:0] KEY_LEN = 4'd15;

  // line phase codes
  localparam logic [2:0] PH_MATCH  = 3'd0;
  localparam logic [2:0] PH_SPACE  = 3'd1;
  localparam logic [2:0] PH_DIGITS = 3'd2;
  localparam logic [2:0] PH_NUMEND = 3'd3;
  localparam logic [2:0] PH_OTHER  = 3'd4;

  typedef struct packed {
    logic [3:0] match_idx;
    logic [2:0] phase;
    logic       cr_pend;
    logic       line_empty;
    logic       minus_seen;
    logic       ovf;
  } ctl_t;

  localparam ctl_t CTL_RESET = '{
    match_idx:  4'd0,
    phase:      PH_MATCH,
    cr_pend:    1'b0,
    line_empty: 1'b1,
    minus_seen: 1'b0,
    ovf:        1'b0
  };

  // lower-case form of "content-length:"
  function automatic logic [7:0] key_char(input logic [3:0] idx);
    logic [7:0] k;
    case (idx)
      4'd0:    k = 8'h63;  // c
      4'd1:    k = 8'h6F;  // o
      4'd2:    k = 8'h6E;  // n
      4'd3:    k = 8'h74;  // t
      4'd4:    k = 8'h65;  // e
      4'd5:    k = 8'h6E;  // n
      4'd6:    k = 8'h74;  // t
      4'd7:    k = 8'h2D;  // -
      4'd8:    k = 8'h6C;  // l
      4'd9:    k = 8'h65;  // e
      4'd10:   k = 8'h6E;  // n
      4'd11:   k = 8'h67;  // g
      4'd12:   k = 8'h74;  // t
      4'd13:   k = 8'h68;  // h
      4'd14:   k = 8'h3A;  // :
      default: k = CH_NUL;
    endcase
    return k;
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= CH_UP_A && c <= CH_UP_Z) ? c + CASE_GAP : c;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
           (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
  endfunction

  // one byte of line content; exceed flags that a digit would overflow
  function automatic ctl_t line_byte(input ctl_t s, input logic [7:0] c,
                                     input logic exceed);
    ctl_t n;
    n = s;
    n.line_empty = 1'b0;
    case (s.phase)
      PH_MATCH: begin
        if (s.match_idx < KEY_LEN && to_lower(c) == key_char(s.match_idx)) begin
          n.match_idx = s.match_idx + 4'd1;
          if (n.match_idx == KEY_LEN) begin
            n.phase = PH_SPACE;
          end
        end else begin
          n.phase = PH_OTHER;
        end
      end
      PH_SPACE: begin
        if (is_space(c)) begin
          n.phase = PH_SPACE;
        end else if (c == CH_PLUS) begin
          n.phase = PH_DIGITS;
        end else if (c == CH_MINUS) begin
          n.minus_seen = 1'b1;
          n.phase = PH_DIGITS;
        end else if (is_digit(c)) begin
          if (!s.ovf && exceed) begin
            n.ovf = 1'b1;
          end
          n.phase = PH_DIGITS;
        end else begin
          n.phase = PH_NUMEND;
        end
      end
      PH_DIGITS: begin
        if (is_digit(c)) begin
          if (!s.ovf && exceed) begin
            n.ovf = 1'b1;
          end
        end else begin
          n.phase = PH_NUMEND;
        end
      end
      default: begin
        n.phase = s.phase;
      end
    endcase
    return n;
  endfunction

endpackage

// ----- design/hcls_if.sv -----
// valid/ready channel interfaces for the content-length scanner
// depends on hcls_pkg

interface hcls_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, output data_byte, output last, input ready);
  modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface hcls_out_if;
  logic                             valid;
  logic                             ready;
  logic [hcls_pkg::OUT_LEN_W-1:0]   content_length;
  logic                             header_end;

  modport source (output valid, output content_length, output header_end, input ready);
  modport sink   (input valid, input content_length, input header_end, output ready);
endinterface

// ----- design/hcls_digit_acc.sv -----
// multiply-by-ten-and-add step of the decimal accumulator with overflow test
// depends on hcls_pkg

module hcls_digit_acc #(
  parameter int LENGTH_WIDTH = 64
) (
  input  logic [LENGTH_WIDTH-1:0] acc,
  input  logic [7:0]              digit_char,
  output logic [LENGTH_WIDTH-1:0] acc_sum,
  output logic                    exceed
);

  localparam int WIDE_W = LENGTH_WIDTH + 4;

  logic [3:0]        digit_off;
  logic [WIDE_W-1:0] wide;

  assign digit_off = 4'(digit_char - hcls_pkg::CH_ZERO);

  // 10*acc + d, never more than four bits above the accumulator
  assign wide = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} +
                {{(WIDE_W-4){1'b0}}, digit_off};

  assign acc_sum = wide[LENGTH_WIDTH-1:0];
  assign exceed  = |wide[WIDE_W-1:LENGTH_WIDTH];

endmodule

// ----- design/http_content_length_scanner.sv -----
// top level of the http content-length scanner
// depends on hcls_pkg, hcls_in_if, hcls_out_if and hcls_digit_acc

// Takes header bytes one word per cycle and tracks CR LF terminated lines. A
// line starting with "Content-Length:" (any case) yields a decimal value:
// leading whitespace skipped, optional sign, digits saturating at
// 2^LENGTH_WIDTH-1, a minus sign negating modulo 2^LENGTH_WIDTH. The value is
// committed at the end of its line and the last such line wins. A blank line
// gives one result word with header_end set, after which bytes are dropped
// until a word with last set rearms the block. A zero byte or a last word
// without a blank line gives the committed value with header_end clear; an
// unfinished line is never committed. Throughput is one word per cycle: the
// byte is registered, the whole per-byte state update (name match, sign,
// multiply-by-ten add with its overflow check over LENGTH_WIDTH+4 bits) is
// combinational from that register, and the result lands in an output
// register. Back-pressure on the result channel stalls the input register.

module http_content_length_scanner #(
  parameter int LENGTH_WIDTH = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  hcls_in_if.sink        in_ch,
  hcls_out_if.source     out_ch
);

  // input register
  logic       in_v_r;
  logic [7:0] byte_r;
  logic       last_r;

  // line and message state
  hcls_pkg::ctl_t          ctl_r, ctl_nxt;
  logic [LENGTH_WIDTH-1:0] acc_r, acc_nxt;
  logic [LENGTH_WIDTH-1:0] com_r, com_nxt;
  logic                    done_r, done_nxt;

  // result register
  logic                    out_v_r;
  logic [LENGTH_WIDTH-1:0] out_len_r;
  logic                    out_hdr_r;

  logic                    adv;
  logic                    fire;
  logic                    in_take;
  logic                    emit;
  logic                    hdr;
  logic [LENGTH_WIDTH-1:0] emit_len;
  logic [LENGTH_WIDTH-1:0] acc_sum;
  logic                    exceed;

  hcls_digit_acc #(
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_digit (
    .acc        (acc_r),
    .digit_char (byte_r),
    .acc_sum    (acc_sum),
    .exceed     (exceed)
  );

  // the processing stage moves whenever the result register can take a word
  assign adv         = !out_v_r || out_ch.ready;
  assign fire        = in_v_r && adv;
  assign in_ch.ready = !in_v_r || adv;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_comb begin
    hcls_pkg::ctl_t s;
    hcls_pkg::ctl_t pre;
    logic           rearm;
    logic           crlf;
    logic           take;

    s        = ctl_r;
    pre      = ctl_r;
    acc_nxt  = acc_r;
    com_nxt  = com_r;
    done_nxt = done_r;
    emit     = 1'b0;
    hdr      = 1'b0;
    rearm    = 1'b0;
    crlf     = 1'b0;
    take     = 1'b0;

    if (fire) begin
      if (done_r) begin
        // message finished, wait for its last word
        rearm = last_r;
      end else if (byte_r == hcls_pkg::CH_NUL) begin
        // end of string
        emit = 1'b1;
        if (last_r) begin
          rearm = 1'b1;
        end else begin
          done_nxt = 1'b1;
        end
      end else begin
        if (ctl_r.cr_pend) begin
          s.cr_pend = 1'b0;
          if (byte_r == hcls_pkg::CH_LF) begin
            crlf = 1'b1;
            if (ctl_r.line_empty) begin
              // blank line closes the header block
              emit = 1'b1;
              hdr  = 1'b1;
              if (last_r) begin
                rearm = 1'b1;
              end else begin
                done_nxt = 1'b1;
              end
            end else begin
              // line complete: commit the value if this was a length line
              if (ctl_r.phase == hcls_pkg::PH_SPACE ||
                  ctl_r.phase == hcls_pkg::PH_DIGITS ||
                  ctl_r.phase == hcls_pkg::PH_NUMEND) begin
                if (ctl_r.ovf) begin
                  com_nxt = '1;
                end else if (ctl_r.minus_seen) begin
                  com_nxt = '0 - acc_r;
                end else begin
                  com_nxt = acc_r;
                end
              end
              s            = hcls_pkg::CTL_RESET;
              acc_nxt      = '0;
              if (last_r) begin
                emit  = 1'b1;
                rearm = 1'b1;
              end
            end
          end else begin
            // lone cr is ordinary line content
            s = hcls_pkg::line_byte(s, hcls_pkg::CH_CR, 1'b0);
          end
        end

        if (!crlf) begin
          if (byte_r == hcls_pkg::CH_CR) begin
            s.cr_pend = 1'b1;
          end else begin
            pre  = s;
            take = hcls_pkg::is_digit(byte_r) && !pre.ovf &&
                   (pre.phase == hcls_pkg::PH_SPACE || pre.phase == hcls_pkg::PH_DIGITS);
            s    = hcls_pkg::line_byte(s, byte_r, exceed);
            if (take && !exceed) begin
              acc_nxt = acc_sum;
            end
          end
          if (last_r) begin
            emit  = 1'b1;
            rearm = 1'b1;
          end
        end
      end
    end

    // value reported is the one committed by this very word, if any
    emit_len = com_nxt;

    if (rearm) begin
      s        = hcls_pkg::CTL_RESET;
      acc_nxt  = '0;
      com_nxt  = '0;
      done_nxt = 1'b0;
    end

    ctl_nxt = s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      ctl_r   <= hcls_pkg::CTL_RESET;
      acc_r   <= '0;
      com_r   <= '0;
      done_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_take) begin
        in_v_r <= 1'b1;
      end else if (fire) begin
        in_v_r <= 1'b0;
      end
      ctl_r  <= ctl_nxt;
      acc_r  <= acc_nxt;
      com_r  <= com_nxt;
      done_r <= done_nxt;
      if (adv) begin
        out_v_r <= fire && emit;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      byte_r <= in_ch.data_byte;
      last_r <= in_ch.last;
    end
    if (fire && emit) begin
      out_len_r <= emit_len;
      out_hdr_r <= hdr;
    end
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.content_length = {{(hcls_pkg::OUT_LEN_W-LENGTH_WIDTH){1'b0}}, out_len_r};
  assign out_ch.header_end     = out_hdr_r;

endmodule

// ----- verif/http_content_length_scanner_test.sv -----
// self-checking testbench for http_content_length_scanner: a table of header blocks,
// then random blocks, every result word checked against a typed-in value or a byte-level scanner model
// depends on hcls_pkg, hcls_in_if, hcls_out_if and the scanner rtl

module http_content_length_scanner_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LEN_W = hcls_pkg::OUT_LEN_W;

  // line endings, written as octal escapes so that every tool reads them alike
  localparam string CR_S = "\015";
  localparam string CRLF = "\015\012";

  // header name as the scanner compares it, letters folded to lower case
  localparam string KEY_TEXT = "content-length:";

  // one result word as it should appear on the output channel
  typedef struct packed {
    logic [LEN_W-1:0] content_length;
    logic             header_end;
  } length_report_t;

  // how a table row is closed off
  typedef enum {END_LAST, END_OPEN, END_NUL, END_NUL_LAST} ending_t;

  typedef struct {
    string          text;
    ending_t        ending;
    bit             fixed_want;  // expected word typed in, not taken from the model
    length_report_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n;

  hcls_in_if  in_ch();
  hcls_out_if out_ch();

  http_content_length_scanner #(
    .LENGTH_WIDTH(LEN_W)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #10 clk = ~clk;

  // result words still owed by the block, oldest first
  length_report_t awaited_reports[$];
  int             failures;
  int             sent_words;    // words accepted by the block over the whole run

  // while set, both sides stream without idle cycles
  bit quiet_spell;

  // bytes of the header block currently being built or sent
  logic [7:0] frame[$];
  row_t       plan[$];

  // ---------------------------------------------------------------------------
  // scanner model: its own copy of the per-line and per-message state
  // ---------------------------------------------------------------------------
  logic [3:0]       key_pos;
  logic [2:0]       stage;
  bit               cr_wait;       // a cr seen, waiting to learn if lf follows
  bit               line_blank;
  logic [LEN_W-1:0] acc;
  bit               negative;
  bit               saturated;
  logic [LEN_W-1:0] held_length;   // last committed content-length value
  bit               msg_closed;    // result given, bytes dropped until last

  function automatic void open_line();
    key_pos    = 4'd0;
    stage      = hcls_pkg::PH_MATCH;
    line_blank = 1'b1;
    acc        = '0;
    negative   = 1'b0;
    saturated  = 1'b0;
  endfunction

  function automatic void rearm();
    open_line();
    cr_wait     = 1'b0;
    held_length = '0;
    msg_closed  = 1'b0;
  endfunction

  // one byte of line content
  function automatic void take_char(input logic [7:0] c);
    logic [7:0]       folded;
    logic [LEN_W-1:0] d;
    bit               numeral;
    bit               blank;
    folded  = (c >= hcls_pkg::CH_UP_A && c <= hcls_pkg::CH_UP_Z) ?
              c + hcls_pkg::CASE_GAP : c;
    numeral = (c >= hcls_pkg::CH_ZERO) && (c <= hcls_pkg::CH_NINE);
    blank   = c == hcls_pkg::CH_SPACE || c == hcls_pkg::CH_TAB || c == hcls_pkg::CH_LF ||
              c == hcls_pkg::CH_VT || c == hcls_pkg::CH_FF || c == hcls_pkg::CH_CR;
    d       = '0;
    d[7:0]  = c - hcls_pkg::CH_ZERO;
    line_blank = 1'b0;
    // digits count both before the sign stage ends and within the number
    if (numeral && (stage == hcls_pkg::PH_SPACE || stage == hcls_pkg::PH_DIGITS) &&
        !saturated) begin
      if (acc > ({LEN_W{1'b1}} - d) / 10) begin
        saturated = 1'b1;
      end else begin
        acc = acc * 10 + d;
      end
    end
    case (stage)
      hcls_pkg::PH_MATCH: begin
        if (key_pos < hcls_pkg::KEY_LEN && folded == KEY_TEXT[key_pos]) begin
          key_pos = key_pos + 4'd1;
          if (key_pos == hcls_pkg::KEY_LEN) begin
            stage = hcls_pkg::PH_SPACE;
          end
        end else begin
          stage = hcls_pkg::PH_OTHER;
        end
      end
      hcls_pkg::PH_SPACE: begin
        if (c == hcls_pkg::CH_PLUS) begin
          stage = hcls_pkg::PH_DIGITS;
        end else if (c == hcls_pkg::CH_MINUS) begin
          negative = 1'b1;
          stage    = hcls_pkg::PH_DIGITS;
        end else if (numeral) begin
          stage = hcls_pkg::PH_DIGITS;
        end else if (!blank) begin
          stage = hcls_pkg::PH_NUMEND;
        end
      end
      hcls_pkg::PH_DIGITS: begin
        if (!numeral) begin
          stage = hcls_pkg::PH_NUMEND;
        end
      end
      default: begin
      end
    endcase
  endfunction

  // a terminated content-length line commits its value, any other line is dropped
  function automatic void close_line();
    if (stage == hcls_pkg::PH_SPACE || stage == hcls_pkg::PH_DIGITS ||
        stage == hcls_pkg::PH_NUMEND) begin
      if (saturated) begin
        held_length = '1;
      end else if (negative) begin
        held_length = -acc;
      end else begin
        held_length = acc;
      end
    end
    open_line();
  endfunction

  // advances the model by one accepted word; returns 1 when a result word is due
  function automatic bit scan_word(input logic [7:0] c, input bit last,
                                   output length_report_t rep);
    rep = '0;
    if (msg_closed) begin
      if (last) begin
        rearm();
      end
      return 1'b0;
    end
    rep.content_length = held_length;
    // zero byte ends the string early
    if (c == hcls_pkg::CH_NUL) begin
      if (last) rearm();
      else msg_closed = 1'b1;
      return 1'b1;
    end
    if (cr_wait) begin
      cr_wait = 1'b0;
      if (c == hcls_pkg::CH_LF) begin
        // blank line: end of headers
        if (line_blank) begin
          rep.header_end = 1'b1;
          if (last) rearm();
          else msg_closed = 1'b1;
          return 1'b1;
        end
        close_line();
        rep.content_length = held_length;
        if (last) begin
          rearm();
          return 1'b1;
        end
        return 1'b0;
      end
      // a cr without its lf is plain line content
      take_char(hcls_pkg::CH_CR);
    end
    if (c == hcls_pkg::CH_CR) begin
      cr_wait = 1'b1;
    end else begin
      take_char(c);
    end
    if (last) begin
      rearm();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // header block builders
  // ---------------------------------------------------------------------------
  function automatic void put_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      frame.push_back(s[i]);
    end
  endfunction

  // random bytes, zero included
  function automatic void put_tail();
    repeat ($urandom_range(1, 6)) frame.push_back(8'($urandom));
  endfunction

  // content-length line with random case, whitespace, sign, digits and trailer
  function automatic void put_length_line();
    logic [7:0] c;
    int         pick;
    int         count;
    for (int i = 0; i < hcls_pkg::KEY_LEN; i++) begin
      c = KEY_TEXT[i];
      if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1) begin
        c = c - hcls_pkg::CASE_GAP;
      end
      frame.push_back(c);
    end
    repeat ($urandom_range(0, 3)) begin
      case ($urandom_range(0, 5))
        0: frame.push_back(hcls_pkg::CH_TAB);
        1: frame.push_back(hcls_pkg::CH_VT);
        2: frame.push_back(hcls_pkg::CH_FF);
        3: frame.push_back(hcls_pkg::CH_LF);
        4: begin
          // lone cr, kept away from an lf so the line goes on
          frame.push_back(hcls_pkg::CH_CR);
          frame.push_back(hcls_pkg::CH_SPACE);
        end
        default: frame.push_back(hcls_pkg::CH_SPACE);
      endcase
    end
    case ($urandom_range(0, 5))
      0: frame.push_back(hcls_pkg::CH_PLUS);
      1: frame.push_back(hcls_pkg::CH_MINUS);
      default: begin
      end
    endcase
    pick = $urandom_range(0, 9);
    if (pick == 1) begin
      // right at the saturation edge
      put_text("1844674407370955161");
      frame.push_back(8'(hcls_pkg::CH_ZERO + $urandom_range(0, 9)));
    end else if (pick != 0) begin
      count = (pick == 2) ? $urandom_range(19, 24) : $urandom_range(1, 7);
      repeat (count) frame.push_back(8'(hcls_pkg::CH_ZERO + $urandom_range(0, 9)));
    end
    if ($urandom_range(0, 4) == 0) begin
      c = 8'($urandom_range(1, 255));
      frame.push_back(c == hcls_pkg::CH_CR ? hcls_pkg::CH_SPACE : c);
      repeat ($urandom_range(0, 2)) begin
        frame.push_back(8'(hcls_pkg::CH_ZERO + $urandom_range(0, 9)));
      end
    end
    put_text(CRLF);
  endfunction

  // any other header line, sometimes a near miss of the content-length name
  function automatic void put_other_line();
    logic [7:0] c;
    int         count;
    if ($urandom_range(0, 5) == 0) begin
      count = $urandom_range(0, 14);
      for (int i = 0; i < count; i++) begin
        frame.push_back(KEY_TEXT[i]);
      end
      frame.push_back("x");
    end else begin
      repeat ($urandom_range(1, 8)) frame.push_back(8'("a" + $urandom_range(0, 25)));
      put_text(": ");
    end
    repeat ($urandom_range(0, 10)) begin
      c = 8'($urandom_range(1, 255));
      frame.push_back(c == hcls_pkg::CH_CR ? hcls_pkg::CH_SPACE : c);
    end
    put_text(CRLF);
  endfunction

  function automatic void add_row(input string text, input ending_t ending,
                                  input bit fixed_want, input logic [LEN_W-1:0] len,
                                  input bit hdr_end);
    row_t r;
    r.text       = text;
    r.ending     = ending;
    r.fixed_want = fixed_want;
    r.want       = '{content_length: len, header_end: hdr_end};
    plan.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------
  task automatic send_word(input logic [7:0] b, input bit last, input bit fixed_want,
                           input length_report_t want);
    int             gap;
    length_report_t rep;
    gap = quiet_spell ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      // idle with junk on the data lines
      in_ch.valid     <= 1'b0;
      in_ch.data_byte <= 8'($urandom);
      in_ch.last      <= 1'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.last      <= last;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sent_words++;
    if (scan_word(b, last, rep)) begin
      awaited_reports.push_back(fixed_want ? want : rep);
    end
  endtask

  task automatic send_frame(input bit end_last, input bit fixed_want,
                            input length_report_t want);
    for (int i = 0; i < frame.size(); i++) begin
      send_word(frame[i], end_last && (i == frame.size() - 1), fixed_want, want);
    end
  endtask

  task automatic send_random_message();
    int pick;
    int count;
    int cut;
    bit end_last;
    frame.delete();
    quiet_spell = ($urandom_range(0, 5) == 0);
    pick        = $urandom_range(0, 9);
    end_last    = 1'b1;
    if (pick == 0) begin
      // line noise; without a last word it runs into the next block
      put_tail();
      put_tail();
      end_last = ($urandom_range(0, 3) == 0);
    end else begin
      count = $urandom_range(0, 4);
      repeat (count) begin
        if ($urandom_range(0, 1) == 1) put_length_line();
        else put_other_line();
      end
      if (pick <= 2) begin
        // broken block: cut anywhere, ended by last or by a zero byte
        put_text(CRLF);
        cut = $urandom_range(0, frame.size() - 1);
        while (frame.size() > cut + 1) frame.delete(frame.size() - 1);
        if ($urandom_range(0, 1) == 1) begin
          frame.push_back(hcls_pkg::CH_NUL);
          if ($urandom_range(0, 1) == 1) put_tail();
        end
      end else begin
        case ($urandom_range(0, 7))
          5: begin
            // bytes after the blank line are dropped until last
            put_text(CRLF);
            put_tail();
          end
          6: begin
            frame.push_back(hcls_pkg::CH_NUL);
            put_tail();
          end
          7: begin
            // last word on the lf of a header line, no blank line
            if (frame.size() == 0) put_text(CRLF);
          end
          default: put_text(CRLF);
        endcase
      end
    end
    send_frame(end_last, 1'b0, '0);
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stalls, then hold ready until a word is taken
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int stall;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = quiet_spell ? 0 : $urandom_range(0, 9);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
    end
  end

  // every word taken off the output is checked against the oldest expectation
  always @(posedge clk) begin : check_results
    length_report_t due;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (awaited_reports.size() == 0) begin
        $error("unexpected result word: content_length %0d header_end %0b",
               out_ch.content_length, out_ch.header_end);
        failures++;
      end else begin
        due = awaited_reports.pop_front();
        if (out_ch.content_length !== due.content_length) begin
          $error("content_length: expected %0d, got %0d",
                 due.content_length, out_ch.content_length);
          failures++;
        end
        if (out_ch.header_end !== due.header_end) begin
          $error("header_end: expected %0b, got %0b", due.header_end, out_ch.header_end);
          failures++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    localparam logic [LEN_W-1:0] ALL_ONES = '1;
    bit end_last;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.data_byte <= hcls_pkg::CH_NUL;
    in_ch.last      <= 1'b0;
    failures    = 0;
    sent_words  = 0;
    quiet_spell = 1'b0;
    rearm();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // blank line straight after reset, last on its lf
    add_row(CRLF, END_LAST, 1'b1, '0, 1'b1);
    // blank line without last: the block then drops bytes until a last word
    add_row({"Content-Length: 42", CRLF, CRLF}, END_OPEN, 1'b1, 64'd42, 1'b1);
    add_row({"ignored", CRLF, "Content-Length: 5", CRLF}, END_LAST, 1'b0, '0, 1'b0);
    // every kind of whitespace before the number, a lone cr among them
    add_row({"CONTENT-length:\t\v\f\n ", CR_S, "7", CRLF, CRLF}, END_LAST, 1'b0, '0, 1'b0);
    // minus sign wraps, the largest value, and saturation with either sign
    add_row({"Content-Length: -1", CRLF, CRLF}, END_LAST, 1'b1, ALL_ONES, 1'b1);
    add_row({"content-length:+18446744073709551615", CRLF, CRLF}, END_LAST, 1'b1,
            ALL_ONES, 1'b1);
    add_row({"Content-Length: 18446744073709551616", CRLF, CRLF}, END_LAST, 1'b1,
            ALL_ONES, 1'b1);
    add_row({"Content-Length: -99999999999999999999", CRLF, CRLF}, END_LAST, 1'b1,
            ALL_ONES, 1'b1);
    // no digits: sign alone, nothing at all, letters
    add_row({"Content-Length: -", CRLF, CRLF}, END_LAST, 1'b1, '0, 1'b1);
    add_row({"Content-Length:", CRLF, CRLF}, END_LAST, 1'b1, '0, 1'b1);
    add_row({"Content-Length: abc", CRLF, CRLF}, END_LAST, 1'b1, '0, 1'b1);
    // the last terminated line wins, junk after the number is ignored
    add_row({"Content-Length: 3", CRLF, "Content-Length: 12 x", CRLF, CRLF}, END_LAST,
            1'b0, '0, 1'b0);
    // unterminated line cut by last is never committed
    add_row({"Content-Length: 9", CRLF, "Content-Length: 77"}, END_LAST, 1'b1,
            64'd9, 1'b0);
    // zero byte with a cr waiting, then dropped bytes up to a last word
    add_row({"Content-Length: 5", CRLF, "X-A: 1", CR_S}, END_NUL, 1'b1, 64'd5, 1'b0);
    add_row("trailing", END_LAST, 1'b0, '0, 1'b0);
    // zero byte carrying last
    add_row("", END_NUL_LAST, 1'b1, '0, 1'b0);
    add_row("Host: x", END_LAST, 1'b1, '0, 1'b0);
    // near misses of the header name
    add_row({"Content-Lengthy: 4", CRLF, "Content-Length 4", CRLF, CRLF}, END_LAST, 1'b1,
            '0, 1'b1);
    // last on a cr, and last on the lf of a header line
    add_row({"Content-Length: 8", CRLF, "A", CR_S}, END_LAST, 1'b1, 64'd8, 1'b0);
    add_row({"Content-Length: 6", CRLF}, END_LAST, 1'b1, 64'd6, 1'b0);
    // top byte values and the characters around the letter ranges
    add_row({"\377\200@[\140{", CRLF, CRLF}, END_LAST, 1'b1, '0, 1'b1);
    add_row({"Content-Length:\t0000123", CRLF, CRLF}, END_LAST, 1'b0, '0, 1'b0);
    // doubled crs make a line non-blank
    add_row({"Content-Length: 4", CRLF, CR_S, CR_S, CRLF, CRLF}, END_LAST, 1'b0, '0, 1'b0);

    foreach (plan[r]) begin
      frame.delete();
      put_text(plan[r].text);
      if (plan[r].ending == END_NUL || plan[r].ending == END_NUL_LAST) begin
        frame.push_back(hcls_pkg::CH_NUL);
      end
      end_last    = (plan[r].ending == END_LAST || plan[r].ending == END_NUL_LAST);
      quiet_spell = ($urandom_range(0, 3) == 0);
      send_frame(end_last, plan[r].fixed_want, plan[r].want);
    end

    // random header blocks, mostly well formed
    while (sent_words < 1550) begin
      send_random_message();
    end
    in_ch.valid <= 1'b0;

    // drain, then keep watching to catch stray result words
    while (awaited_reports.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // hang guard, far beyond the slowest correct run
  initial begin : watchdog
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
